/* rtl/tsba_pkg.sv */
// Shared types, constants and tables for the tabular SARSA balance agent.
// No dependencies; used by tsba_quant, tsba_cfg, the top level and the testbench.
`timescale 1ns / 1ps
package tsba_pkg;

    localparam int NUM_ACTIONS_DEF  = 7;
    localparam int PITCH_BOUNDS_DEF = 9;
    localparam int RATE_BOUNDS_DEF  = 11;
    localparam int Q_WIDTH_DEF      = 32;

    localparam int PITCH_W  = 16;   // Q8.8 degrees
    localparam int FRAC_W   = 16;   // Q0.16 fractions
    localparam int RATE_W   = 22;   // 25 * 17-bit pitch change
    localparam int REWARD_W = 32;
    localparam int CFG_AW   = 5;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_EXPLORE = 3'd0;
    localparam logic [2:0] REG_LEARN   = 3'd1;
    localparam logic [2:0] REG_DISC    = 3'd2;
    localparam logic [2:0] REG_UPPER   = 3'd3;
    localparam logic [2:0] REG_LOWER   = 3'd4;

    localparam logic [15:0]        EXPLORE_RST = 16'd39322;
    localparam logic [15:0]        LEARN_RST   = 16'd26214;
    localparam logic [15:0]        DISC_RST    = 16'd19661;
    localparam logic signed [15:0] UPPER_RST   = 16'sd1408;
    localparam logic signed [15:0] LOWER_RST   = -16'sd384;

    typedef struct packed {
        logic [15:0]        explore_rate;
        logic [15:0]        learn_rate;
        logic [15:0]        discount;
        logic signed [15:0] pitch_upper_limit;
        logic signed [15:0] pitch_lower_limit;
    } cfg_t;

    localparam logic signed [15:0] PITCH_EDGES [16] = '{
        -16'sd256, 16'sd0, 16'sd256, 16'sd384, 16'sd512, 16'sd640, 16'sd768,
        16'sd1024, 16'sd1280, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
        16'sd32767, 16'sd32767, 16'sd32767};

    localparam logic signed [15:0] RATE_EDGES [16] = '{
        -16'sd1280, -16'sd1024, -16'sd768, -16'sd512, -16'sd256, 16'sd0,
        16'sd256, 16'sd512, 16'sd768, 16'sd1024, 16'sd1280, 16'sd32767,
        16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};

    localparam logic signed [6:0] FORCE_TABLE [16] = '{
        -7'sd53, -7'sd26, -7'sd13, 7'sd0, 7'sd13, 7'sd26, 7'sd53, 7'sd0,
        7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0, 7'sd0};

endpackage

/* rtl/tsba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tsba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 840
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/tsba_mul.sv */
// Shared signed multiplier with a registered product.
// No dependencies.
`timescale 1ns / 1ps
module tsba_mul #(
    parameter int A_W = 32,
    parameter int B_W = 22
) (
    input  logic                        clk,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [B_W-1:0]       b,
    output logic signed [A_W+B_W-1:0]   prod
);

    always_ff @(posedge clk)
    begin
        prod <= a * b;
    end

endmodule

/* rtl/tsba_quant.sv */
// Pitch and rate quantizer: bins both values and forms the state index.
// Depends on tsba_pkg (threshold tables).
`timescale 1ns / 1ps
module tsba_quant
    import tsba_pkg::*;
#(
    parameter int PITCH_BOUNDS = PITCH_BOUNDS_DEF,
    parameter int RATE_BOUNDS  = RATE_BOUNDS_DEF,
    localparam int SW = $clog2((PITCH_BOUNDS + 1) * (RATE_BOUNDS + 1))
) (
    input  logic signed [PITCH_W-1:0] pitch,
    input  logic signed [RATE_W-1:0]  rate,
    output logic [SW-1:0]             state_idx
);

    localparam int PBW = $clog2(PITCH_BOUNDS + 1);
    localparam int RBW = $clog2(RATE_BOUNDS + 1);

    logic [PBW-1:0]           pbin;
    logic [RBW-1:0]           rbin;
    logic signed [RATE_W-1:0] rate_c;

    // thresholds are sorted, so the first edge >= value is the count of edges below it
    always_comb
    begin
        pbin = '0;
        rbin = '0;
        // rate is clipped to the 16-bit top before binning
        rate_c = (rate > RATE_W'(16'sd32767)) ? RATE_W'(16'sd32767) : rate;
        for (int k = 0; k < PITCH_BOUNDS; k++)
        begin
            if (pitch > PITCH_EDGES[k])
            begin
                pbin = pbin + PBW'(1);
            end
        end
        for (int k = 0; k < RATE_BOUNDS; k++)
        begin
            if (rate_c > RATE_W'(RATE_EDGES[k]))
            begin
                rbin = rbin + RBW'(1);
            end
        end
        state_idx = SW'(rbin) + SW'(SW'(pbin) * SW'(RATE_BOUNDS + 1));
    end

endmodule

/* rtl/tsba_cfg.sv */
// APB register file for the agent's learning and limit settings.
// Depends on tsba_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps
module tsba_cfg
    import tsba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[CFG_AW-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.explore_rate      <= EXPLORE_RST;
            cfg_reg.learn_rate        <= LEARN_RST;
            cfg_reg.discount          <= DISC_RST;
            cfg_reg.pitch_upper_limit <= UPPER_RST;
            cfg_reg.pitch_lower_limit <= LOWER_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_EXPLORE: cfg_reg.explore_rate      <= pwdata[15:0];
                REG_LEARN:   cfg_reg.learn_rate        <= pwdata[15:0];
                REG_DISC:    cfg_reg.discount          <= pwdata[15:0];
                REG_UPPER:   cfg_reg.pitch_upper_limit <= pwdata[15:0];
                REG_LOWER:   cfg_reg.pitch_lower_limit <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_EXPLORE: prdata = {16'd0, cfg_reg.explore_rate};
            REG_LEARN:   prdata = {16'd0, cfg_reg.learn_rate};
            REG_DISC:    prdata = {16'd0, cfg_reg.discount};
            REG_UPPER:   prdata = {16'd0, cfg_reg.pitch_upper_limit};
            REG_LOWER:   prdata = {16'd0, cfg_reg.pitch_lower_limit};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/tabular_sarsa_balance_agent.sv */
// Top level of the tabular SARSA balance agent: sequencer, Q-table, datapath.
// Depends on tsba_pkg, tsba_ram, tsba_mul, tsba_quant and tsba_cfg.
`timescale 1ns / 1ps
//
// Usage
//  - Input stream (s_axis_*): one transaction per control tick carrying the
//    pitch (Q8.8 deg), a Q0.16 random fraction and a random action index.
//  - Output stream (m_axis_*): exactly one transaction per input. tuser says
//    whether an action was applied or the episode restarted; tdata carries
//    state, action, wheel force and the Q16.16 reward.
//  - APB port: five 16-bit registers at byte offsets 0,4,8,12,16 (epsilon,
//    alpha, gamma, upper and lower pitch limit). Write only while idle.
//  - Timing: one transaction at a time. An in-range tick's result waits on the
//    serial Q-row scan through the single RAM read port and, except on an
//    episode's first step, four passes through the shared multiplier.
//    Out-of-range ticks skip both and go straight to the output register.
//    s_axis_tready rises together with the result.
//  - Reset: the Q table is swept to zero, one entry per cycle, through all
//    NUM_STATES*NUM_ACTIONS entries (840 by default); s_axis_tready stays low
//    during the sweep. Registers return to their reset values.
//  - Stall: the result sits in the output register until m_axis_tready; a new
//    tick is accepted meanwhile, and its result waits for that register.
//
module tabular_sarsa_balance_agent
    import tsba_pkg::*;
#(
    parameter int NUM_ACTIONS  = NUM_ACTIONS_DEF,
    parameter int PITCH_BOUNDS = PITCH_BOUNDS_DEF,
    parameter int RATE_BOUNDS  = RATE_BOUNDS_DEF,
    parameter int Q_WIDTH      = Q_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,   // pitch_deg, rand_fraction, rand_action
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [55:0]       m_axis_tdata,   // state_index, action_index, wheel_force, reward
    output logic [1:0]        m_axis_tuser,   // applied, episode_restart
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int NUM_STATES = (PITCH_BOUNDS + 1) * (RATE_BOUNDS + 1);
    localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
    localparam int ADW   = $clog2(DEPTH);
    localparam int SW    = $clog2(NUM_STATES);
    localparam int AIW   = $clog2(NUM_ACTIONS);
    localparam int CW    = $clog2(NUM_ACTIONS + 1);
    localparam int MA    = (Q_WIDTH > RATE_W) ? Q_WIDTH : RATE_W;
    localparam int PW    = MA + RATE_W;
    localparam int EW    = ((Q_WIDTH > REWARD_W) ? Q_WIDTH : REWARD_W) + 2;

    // sequencer states
    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_RATE = 4'd2;
    localparam logic [3:0] ST_BIN  = 4'd3;
    localparam logic [3:0] ST_SCAN = 4'd4;
    localparam logic [3:0] ST_PICK = 4'd5;
    localparam logic [3:0] ST_P2   = 4'd6;
    localparam logic [3:0] ST_R2   = 4'd7;
    localparam logic [3:0] ST_REW  = 4'd8;
    localparam logic [3:0] ST_TGT  = 4'd9;
    localparam logic [3:0] ST_ERR  = 4'd10;
    localparam logic [3:0] ST_MULA = 4'd11;
    localparam logic [3:0] ST_UPD  = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    localparam logic signed [EW-1:0] Q_MAX_E =
        $signed({{(EW - Q_WIDTH + 1){1'b0}}, {(Q_WIDTH - 1){1'b1}}});
    localparam logic signed [EW-1:0] Q_MIN_E =
        $signed({{(EW - Q_WIDTH + 1){1'b1}}, {(Q_WIDTH - 1){1'b0}}});
    localparam logic signed [PW:0] R_MAX_E =
        $signed({{(PW + 1 - REWARD_W){1'b0}}, 1'b0, {(REWARD_W - 1){1'b1}}});
    localparam logic signed [PW:0] R_MIN_E =
        $signed({{(PW + 1 - REWARD_W){1'b1}}, 1'b1, {(REWARD_W - 1){1'b0}}});

    function automatic logic signed [Q_WIDTH-1:0] sat_q(input logic signed [EW-1:0] x);
        if (x > Q_MAX_E)
        begin
            return Q_MAX_E[Q_WIDTH-1:0];
        end
        if (x < Q_MIN_E)
        begin
            return Q_MIN_E[Q_WIDTH-1:0];
        end
        return x[Q_WIDTH-1:0];
    endfunction

    function automatic logic signed [REWARD_W-1:0] sat_r(input logic signed [PW:0] x);
        if (x > R_MAX_E)
        begin
            return R_MAX_E[REWARD_W-1:0];
        end
        if (x < R_MIN_E)
        begin
            return R_MIN_E[REWARD_W-1:0];
        end
        return x[REWARD_W-1:0];
    endfunction

    // random action modulo NUM_ACTIONS by repeated subtraction (3-bit input)
    function automatic logic [AIW-1:0] act_mod(input logic [2:0] ra);
        logic [4:0] r;
        r = {2'b00, ra};
        for (int k = 0; k < 4; k++)
        begin
            if (r >= 5'(NUM_ACTIONS))
            begin
                r = r - 5'(NUM_ACTIONS);
            end
        end
        return AIW'(r);
    endfunction

    cfg_t cfg;

    // control state
    logic [3:0]                   state_reg, state_next;
    logic [ADW-1:0]               clr_reg, clr_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic signed [PITCH_W-1:0]    prev_reg, prev_next;
    logic [SW-1:0]                cur_s_reg, cur_s_next;
    logic [AIW-1:0]               cur_a_reg, cur_a_next;
    logic                         started_reg, started_next;
    logic                         m_valid_reg, m_valid_next;

    // payload
    logic signed [PITCH_W-1:0]    pitch_reg, pitch_next;
    logic [FRAC_W-1:0]            rf_reg, rf_next;
    logic [AIW-1:0]               ra_reg, ra_next;
    logic signed [RATE_W-1:0]     rate_reg, rate_next;
    logic [SW-1:0]                s_reg, s_next;
    logic signed [Q_WIDTH-1:0]    best_reg, best_next;
    logic [AIW-1:0]               best_idx_reg, best_idx_next;
    logic signed [Q_WIDTH-1:0]    cap_reg, cap_next;
    logic [AIW-1:0]               a_reg, a_next;
    logic signed [Q_WIDTH-1:0]    qn_reg, qn_next;
    logic                         restart_reg, restart_next;
    logic signed [PW-1:0]         p2_reg, p2_next;
    logic signed [REWARD_W-1:0]   reward_reg, reward_next;
    logic signed [Q_WIDTH-1:0]    target_reg, target_next;
    logic signed [Q_WIDTH-1:0]    qc_reg, qc_next;
    logic signed [Q_WIDTH-1:0]    err_reg, err_next;
    logic [55:0]                  m_data_reg, m_data_next;
    logic [1:0]                   m_user_reg, m_user_next;

    // datapath wires
    logic                         ram_we;
    logic [ADW-1:0]               ram_waddr, ram_raddr;
    logic [Q_WIDTH-1:0]           ram_wdata, ram_rdata;
    logic signed [Q_WIDTH-1:0]    q_rd;
    logic signed [MA-1:0]         mul_a;
    logic signed [RATE_W-1:0]     mul_b;
    logic signed [PW-1:0]         prod;
    logic signed [PW-17:0]        prod_sh;
    logic [SW-1:0]                s_quant;
    logic signed [16:0]           diff;
    logic [ADW-1:0]               row_base, prev_addr;
    logic [AIW-1:0]               scan_i;
    logic                         explore;
    logic                         same_sign;
    logic signed [PW:0]           rew_wide;
    logic signed [6:0]            force_val;
    logic                         accept;

    assign q_rd     = $signed(ram_rdata);
    assign prod_sh  = prod[PW-1:16];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign row_base = ADW'(ADW'(s_reg) * ADW'(NUM_ACTIONS));
    assign prev_addr = ADW'(ADW'(cur_s_reg) * ADW'(NUM_ACTIONS) + ADW'(cur_a_reg));
    assign scan_i   = AIW'(cnt_reg - CW'(1));
    assign explore  = rf_reg < cfg.explore_rate;
    assign diff     = 17'(pitch_reg) - 17'(prev_reg);
    assign same_sign = (rate_reg < 0 && pitch_reg < 0) || (rate_reg > 0 && pitch_reg > 0);
    assign force_val = FORCE_TABLE[4'(a_reg)];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    tsba_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsba_ram #(
        .WIDTH (Q_WIDTH),
        .DEPTH (DEPTH)
    ) u_qtab (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tsba_mul #(
        .A_W (MA),
        .B_W (RATE_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    tsba_quant #(
        .PITCH_BOUNDS (PITCH_BOUNDS),
        .RATE_BOUNDS  (RATE_BOUNDS)
    ) u_quant (
        .pitch     (pitch_reg),
        .rate      (rate_reg),
        .state_idx (s_quant)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_P2:
            begin
                mul_a = MA'(pitch_reg);
                mul_b = RATE_W'(pitch_reg);
            end
            ST_R2:
            begin
                mul_a = MA'(rate_reg);
                mul_b = rate_reg;
            end
            ST_REW:
            begin
                mul_a = MA'(qn_reg);
                mul_b = RATE_W'($signed({1'b0, cfg.discount}));
            end
            ST_MULA:
            begin
                mul_a = MA'(err_reg);
                mul_b = RATE_W'($signed({1'b0, cfg.learn_rate}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // reward: -pitch^2, rate^2 flipped when pitch and rate share a sign
    always_comb
    begin
        if (same_sign)
        begin
            rew_wide = -(PW + 1)'(prod) - (PW + 1)'(p2_reg);
        end
        else
        begin
            rew_wide = (PW + 1)'(prod) - (PW + 1)'(p2_reg);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        prev_next     = prev_reg;
        cur_s_next    = cur_s_reg;
        cur_a_next    = cur_a_reg;
        started_next  = started_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        pitch_next    = pitch_reg;
        rf_next       = rf_reg;
        ra_next       = ra_reg;
        rate_next     = rate_reg;
        s_next        = s_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        cap_next      = cap_reg;
        a_next        = a_reg;
        qn_next       = qn_reg;
        restart_next  = restart_reg;
        p2_next       = p2_reg;
        reward_next   = reward_reg;
        target_next   = target_reg;
        qc_next       = qc_reg;
        err_next      = err_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        ram_we        = 1'b0;
        ram_waddr     = prev_addr;
        ram_wdata     = '0;
        ram_raddr     = ADW'(row_base + ADW'(cnt_reg[AIW-1:0]));

        unique case (state_reg)
            ST_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + ADW'(1);
                if (clr_reg == ADW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    pitch_next = s_axis_tdata[15:0];
                    rf_next    = s_axis_tdata[31:16];
                    ra_next    = act_mod(s_axis_tdata[34:32]);
                    state_next = ST_RATE;
                end
            end
            ST_RATE:
            begin
                // 25 * delta as shifts and adds
                rate_next = (RATE_W'(diff) <<< 4) + (RATE_W'(diff) <<< 3) + RATE_W'(diff);
                if (pitch_reg > cfg.pitch_upper_limit || pitch_reg < cfg.pitch_lower_limit)
                begin
                    restart_next = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    restart_next = 1'b0;
                    state_next   = ST_BIN;
                end
            end
            ST_BIN:
            begin
                s_next     = s_quant;
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // read for cnt, data of cnt-1 arrives this cycle
                if (cnt_reg != CW'(0))
                begin
                    if (scan_i == '0 || q_rd > best_reg)
                    begin
                        best_next     = q_rd;
                        best_idx_next = scan_i;
                    end
                    if (scan_i == ra_reg)
                    begin
                        cap_next = q_rd;
                    end
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(NUM_ACTIONS))
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                a_next  = explore ? ra_reg : best_idx_reg;
                qn_next = explore ? cap_reg : best_reg;
                if (started_reg)
                begin
                    state_next = ST_P2;
                end
                else
                begin
                    reward_next = '0;
                    state_next  = ST_OUT;
                end
            end
            ST_P2:
            begin
                state_next = ST_R2;
            end
            ST_R2:
            begin
                p2_next    = prod;
                state_next = ST_REW;
            end
            ST_REW:
            begin
                reward_next = sat_r(rew_wide);
                ram_raddr   = prev_addr;
                state_next  = ST_TGT;
            end
            ST_TGT:
            begin
                target_next = sat_q(EW'(reward_reg) + EW'(prod_sh));
                qc_next     = q_rd;
                state_next  = ST_ERR;
            end
            ST_ERR:
            begin
                err_next   = sat_q(EW'(target_reg) - EW'(qc_reg));
                state_next = ST_MULA;
            end
            ST_MULA:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = prev_addr;
                ram_wdata  = sat_q(EW'(qc_reg) + EW'(prod_sh));
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    if (restart_reg)
                    begin
                        m_user_next  = 2'b10;
                        m_data_next  = '0;
                        prev_next    = '0;
                        started_next = 1'b0;
                    end
                    else
                    begin
                        m_user_next  = 2'b01;
                        m_data_next  = {7'd0, reward_reg, force_val, 3'(a_reg), 7'(s_reg)};
                        prev_next    = pitch_reg;
                        cur_s_next   = s_reg;
                        cur_a_next   = a_reg;
                        started_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            prev_reg    <= '0;
            cur_s_reg   <= '0;
            cur_a_reg   <= '0;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
            prev_reg    <= prev_next;
            cur_s_reg   <= cur_s_next;
            cur_a_reg   <= cur_a_next;
            started_reg <= started_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pitch_reg    <= pitch_next;
        rf_reg       <= rf_next;
        ra_reg       <= ra_next;
        rate_reg     <= rate_next;
        s_reg        <= s_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        cap_reg      <= cap_next;
        a_reg        <= a_next;
        qn_reg       <= qn_next;
        restart_reg  <= restart_next;
        p2_reg       <= p2_next;
        reward_reg   <= reward_next;
        target_reg   <= target_next;
        qc_reg       <= qc_next;
        err_reg      <= err_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

`ifndef ASSERT_OFF
    // one transaction at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("input accepted while busy");

    // every result is either applied or a restart, never both
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] != m_axis_tuser[1]))
        else $error("result kind flags inconsistent");

    // outside the clear sweep the table is only written on a started episode
    a_update_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != ST_CLR) |-> started_reg)
        else $error("Q update without a previous step");
`endif

endmodule

/* tb/tb_tabular_sarsa_balance_agent.sv */
// Self-checking testbench for tabular_sarsa_balance_agent: stream and APB stimulus,
// a SARSA prediction model, and an in-order compare of every result.
// Depends on tsba_pkg and the block's RTL; needs no other file.
`timescale 1ns / 1ps
module tb_tabular_sarsa_balance_agent;
    import tsba_pkg::*;

    localparam int N_ACT    = 7;
    localparam int N_STATES = 120;
    localparam int IDLE_GAP = 40;    // idle margin after draining, before register writes
    localparam int WD_LIMIT = 3000;  // covers the Q-table clear sweep after reset

    typedef struct packed {
        logic [2:0]  rand_action;
        logic [15:0] rand_fraction;
        logic [15:0] pitch;
    } tick_t;

    typedef struct {
        bit               applied;
        bit               restart;
        bit [6:0]         state_idx;
        bit [2:0]         action;
        bit signed [6:0]  wheel;
        bit signed [31:0] reward;
    } drive_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // pitch_deg, rand_fraction, rand_action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;        // state_index, action_index, wheel_force, reward
    logic [1:0]  m_axis_tuser;        // applied, episode_restart
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tabular_sarsa_balance_agent u_top (.*);

    initial begin
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Agent model: Q table, episode state and register shadow
    // ---------------------------------------------------------------
    longint      q_mem [N_STATES*N_ACT];
    int          last_pitch;
    int unsigned prev_state;
    int unsigned prev_action;
    bit          in_episode;
    cfg_t        cfg;

    tick_t  tick_q [$];     // ticks waiting to be sent
    drive_t drive_q [$];    // predicted results not yet seen
    bit     failed = 0;
    bit     hold_sender = 0;

    function automatic longint clip(input longint x, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    function automatic int unsigned bin_idx(input longint v, input bit is_rate);
        int unsigned n;
        n = is_rate ? 11 : 9;
        for (int unsigned k = 0; k < n; k++) begin
            if (v <= (is_rate ? longint'(RATE_EDGES[k]) : longint'(PITCH_EDGES[k])))
                return k;
        end
        return n;
    endfunction

    function automatic drive_t sarsa_step(input tick_t t);
        drive_t      r;
        int          p;
        longint      rate, p2, r2, rew, qn, qc, tgt, err;
        int unsigned s, a, idx;
        r = '{default: 0};
        p = int'($signed(t.pitch));
        if (p > cfg.pitch_upper_limit || p < cfg.pitch_lower_limit) begin
            last_pitch = 0;
            in_episode = 0;
            r.restart = 1;
            return r;
        end
        rate = 25 * (longint'(p) - longint'(last_pitch));
        s = bin_idx(rate, 1) + 12 * bin_idx(p, 0);
        // epsilon-greedy; greedy takes the lowest index among ties
        if (t.rand_fraction < cfg.explore_rate) begin
            a = t.rand_action % N_ACT;
        end
        else begin
            a = 0;
            for (int unsigned k = 1; k < N_ACT; k++)
                if (q_mem[s*N_ACT+k] > q_mem[s*N_ACT+a]) a = k;
        end
        rew = 0;
        if (in_episode) begin
            idx = prev_state * N_ACT + prev_action;
            p2 = longint'(p) * p;
            r2 = rate * rate;
            if ((rate < 0 && p < 0) || (rate > 0 && p > 0)) r2 = -r2;
            rew = clip(r2 - p2, 32);
            qn = q_mem[s*N_ACT+a];
            qc = q_mem[idx];
            tgt = clip(rew + ((qn * longint'(cfg.discount)) >>> 16), 32);
            err = clip(tgt - qc, 32);
            q_mem[idx] = clip(qc + ((err * longint'(cfg.learn_rate)) >>> 16), 32);
        end
        prev_state  = s;
        prev_action = a;
        last_pitch  = p;
        in_episode  = 1;
        r.applied   = 1;
        r.state_idx = 7'(s);
        r.action    = 3'(a);
        r.wheel     = FORCE_TABLE[a];
        r.reward    = 32'(rew);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps
    // ---------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk) begin
        bit    send;
        tick_t t;
        send = 0;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                t = tick_q.pop_front();
                drive_q = {drive_q, sarsa_step(t)};
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                else if (tick_q.size() > 0 && !hold_sender) begin
                    send = 1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 25);
                    end
                end
            end
            else begin
                send = 1;   // keep the offered transaction up until taken
            end
        end
        s_axis_tvalid <= send;
        if (send) s_axis_tdata <= {5'd0, tick_q[0]};
    end

    // ---------------------------------------------------------------
    // Receiver: stall pattern of its own, then compare in order
    // ---------------------------------------------------------------
    int stall_phase = 0;
    int mode_left = 0;
    int rx_mode = 0;

    always @(posedge clk) begin
        drive_t exp_r;
        bit     rdy;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (drive_q.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b",
                         $time, m_axis_tdata, m_axis_tuser);
                failed = 1;
            end
            else begin
                exp_r = drive_q.pop_front();
                if (m_axis_tuser !== {exp_r.restart, exp_r.applied} ||
                    m_axis_tdata[6:0] !== exp_r.state_idx ||
                    m_axis_tdata[9:7] !== exp_r.action ||
                    m_axis_tdata[16:10] !== exp_r.wheel ||
                    m_axis_tdata[48:17] !== exp_r.reward ||
                    m_axis_tdata[55:49] !== 7'd0) begin
                    $display("%0t: mismatch exp app=%0d rst=%0d st=%0d act=%0d f=%0d rw=%0d",
                             $time, exp_r.applied, exp_r.restart, exp_r.state_idx,
                             exp_r.action, exp_r.wheel, exp_r.reward);
                    $display("%0t:          got app=%0d rst=%0d st=%0d act=%0d f=%0d rw=%0d",
                             $time, m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[6:0],
                             m_axis_tdata[9:7], $signed(m_axis_tdata[16:10]),
                             $signed(m_axis_tdata[48:17]));
                    failed = 1;
                end
            end
        end
        // modes: always ready, periodic stall, random stall
        if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        stall_phase = (stall_phase + 1) % 7;
        case (rx_mode)
            0: rdy = 1;
            1: rdy = stall_phase < 3;
            default: rdy = $urandom_range(0, 3) != 0;
        endcase
        m_axis_tready <= rdy;
    end

    // Watchdog: cycles with no transaction on any of the three ports
    int quiet = 0;

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WD_LIMIT) begin
            $display("tabular_sarsa_balance_agent regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence: register writes between phases, stimulus per phase
    // ---------------------------------------------------------------
    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        case (idx)
            REG_EXPLORE: cfg.explore_rate      = val;
            REG_LEARN:   cfg.learn_rate        = val;
            REG_DISC:    cfg.discount          = val;
            REG_UPPER:   cfg.pitch_upper_limit = val;
            default:     cfg.pitch_lower_limit = val;
        endcase
    endtask

    task automatic drain();
        while (tick_q.size() > 0 || drive_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic set_cfg(input logic [15:0] e, input logic [15:0] l, input logic [15:0] d,
                           input logic [15:0] up, input logic [15:0] lo);
        drain();
        reg_write(REG_EXPLORE, e);
        reg_write(REG_LEARN, l);
        reg_write(REG_DISC, d);
        reg_write(REG_UPPER, up);
        reg_write(REG_LOWER, lo);
    endtask

    task automatic add_tick(input logic [15:0] p, input logic [15:0] f, input logic [2:0] a);
        tick_t t;
        t.pitch = p;
        t.rand_fraction = f;
        t.rand_action = a;
        tick_q = {tick_q, t};
    endtask

    // Mostly episodes that walk slowly through the in-range band, so rate bins
    // and Q values develop; some wild pitches and out-of-range restarts.
    task automatic random_ticks(input int n);
        int walk;
        int lo, hi, kind;
        walk = 0;
        lo = cfg.pitch_lower_limit;
        hi = cfg.pitch_upper_limit;
        if (lo > hi) begin
            lo = -384;
            hi = 1408;
        end
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                walk += $urandom_range(0, 120) - 60;
                if (walk > hi) walk = hi;
                if (walk < lo) walk = lo;
                add_tick(walk[15:0], 16'($urandom), 3'($urandom_range(0, 7)));
            end
            else if (kind < 92) begin
                walk = $urandom_range(0, 65535);
                add_tick(walk[15:0], 16'($urandom), 3'($urandom_range(0, 7)));
                walk = int'($signed(walk[15:0]));
            end
            else begin
                add_tick($urandom_range(0, 1) ? 16'(16'sh7FFF - $urandom_range(0, 60))
                                              : 16'(16'sh8000 + $urandom_range(0, 60)),
                         16'($urandom), 3'($urandom_range(0, 7)));
                walk = 0;
            end
            if (i == n / 2) begin
                // sender holds off until every result is back
                while (tick_q.size() > n - i - 1) @(posedge clk);
                hold_sender = 1;
                while (drive_q.size() > 0 || s_axis_tvalid) @(posedge clk);
                hold_sender = 0;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < N_STATES*N_ACT; i++) q_mem[i] = 0;
        last_pitch  = 0;
        prev_state  = 0;
        prev_action = 0;
        in_episode  = 0;
        cfg = '{EXPLORE_RST, LEARN_RST, DISC_RST, UPPER_RST, LOWER_RST};
        repeat (2) @(posedge clk);
        rst_n <= 1;
        while (!s_axis_tready) @(posedge clk);

        // directed: thresholds, limits, rate extremes, restarts, action wrap
        add_tick(16'd0, 16'd0, 3'd0);           // first step of an episode
        add_tick(16'd0, 16'hFFFF, 3'd0);        // greedy, all-zero row ties
        add_tick(16'hFF00, 16'd0, 3'd7);        // -1 deg, random action 7 wraps
        add_tick(16'hFE80, 16'd0, 3'd6);        // lower limit exactly
        add_tick(16'd1408, 16'd0, 3'd1);        // jump to upper limit, big rate
        add_tick(16'hFE80, 16'hFFFF, 3'd2);     // big negative jump
        add_tick(16'd1409, 16'd0, 3'd0);        // just above upper: restart
        add_tick(16'd256, 16'd0, 3'd4);         // first step after restart
        add_tick(16'd384, 16'd39321, 3'd5);     // just below epsilon
        add_tick(16'd512, 16'd39322, 3'd3);     // epsilon itself: greedy
        add_tick(16'd640, 16'd100, 3'd6);
        add_tick(16'd768, 16'd200, 3'd2);
        add_tick(16'd1024, 16'd300, 3'd1);
        add_tick(16'd1280, 16'd400, 3'd0);
        add_tick(16'd1281, 16'hFFFF, 3'd7);
        add_tick(16'hFE7F, 16'd0, 3'd0);        // just below lower: restart
        add_tick(16'h7FFF, 16'd0, 3'd0);
        add_tick(16'h8000, 16'd0, 3'd0);
        add_tick(16'd1, 16'd0, 3'd5);
        add_tick(16'hFFFF, 16'd0, 3'd4);

        // greedy only, full-scale alpha and gamma, every pitch in range
        set_cfg(16'd0, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000);
        random_ticks(450);
        // explore on all but the top fraction, frozen table
        set_cfg(16'hFFFF, 16'd0, 16'd0, UPPER_RST, LOWER_RST);
        random_ticks(350);
        // crossed limits: every tick restarts
        set_cfg(16'd1000, 16'd3000, 16'd4000, 16'shFF9C, 16'sd100);
        random_ticks(25);
        // random registers
        set_cfg(16'($urandom), 16'($urandom), 16'($urandom),
                16'(16'sd1000 + $urandom_range(0, 2000)),
                16'(16'shFC00 + $urandom_range(0, 900)));
        random_ticks(500);
        set_cfg(16'd8000, 16'd60000, 16'd50000, UPPER_RST, LOWER_RST);
        random_ticks(550);

        drain();
        if (!failed)
            $display("tabular_sarsa_balance_agent regression: pass");
        else
            $display("tabular_sarsa_balance_agent regression: fail");
        $finish;
    end

endmodule
